### rtl/core/prle_pkg.sv
package prle_pkg;

    localparam int unsigned MAX_CHANNELS = 4;
    localparam int unsigned CHAN_CAP     = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;
    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam logic [7:0] RUN_LIMIT        = 8'd255;
    localparam logic [2:0] CHAN_COUNT_RESET = 3'd3;

    typedef struct packed {
        logic [7:0]  count;
        logic [31:0] pixel;
        logic        last;
    } record_t;

    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        record_t first;
        record_t second;
    } push_t;

    function automatic logic [31:0] chan_mask(input logic [2:0] cc);
        logic [2:0]  n;
        logic [31:0] m;
        n = cc;
        if (n == 3'd0)
        begin
            n = 3'd1;
        end
        if (n > 3'(CHAN_CAP))
        begin
            n = 3'(CHAN_CAP);
        end
        for (int k = 0; k < 4; k++)
        begin
            m[8*k +: 8] = (3'(k) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

### rtl/core/prle_front.sv
module prle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              channel_count_we,
    input  logic [2:0]        channel_count,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        chan0,
    input  logic [7:0]        chan1,
    input  logic [7:0]        chan2,
    input  logic [7:0]        chan3,
    input  logic              final_pixel,
    input  logic              space_ok,
    output prle_pkg::push_t   push
);
    import prle_pkg::*;

    logic [2:0]  chan_count_reg;
    logic [31:0] run_pixel_reg, run_pixel_next;
    logic [7:0]  run_length_reg, run_length_next;
    logic        run_open_reg, run_open_next;

    logic [31:0] mask;
    logic [31:0] pix;
    logic        accept;
    logic        extend;
    logic        brk_emit;
    logic [7:0]  len1;
    logic [31:0] pix1;
    record_t     rec_brk;
    record_t     rec_fin;

    assign in_ready = space_ok;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mask     = chan_mask(chan_count_reg);
        pix      = {chan3, chan2, chan1, chan0} & mask;
        extend   = run_open_reg && (pix == (run_pixel_reg & mask))
                   && (run_length_reg != RUN_LIMIT);
        brk_emit = run_open_reg && !extend;
        len1     = extend ? run_length_reg + 8'd1 : 8'd1;
        pix1     = extend ? run_pixel_reg : pix;

        rec_brk.count = run_length_reg;
        rec_brk.pixel = run_pixel_reg & mask;
        rec_brk.last  = 1'b0;
        rec_fin.count = len1;
        rec_fin.pixel = pix1 & mask;
        rec_fin.last  = 1'b1;

        push.first_valid  = accept && (brk_emit || final_pixel);
        push.second_valid = accept && brk_emit && final_pixel;
        push.first        = brk_emit ? rec_brk : rec_fin;
        push.second       = rec_fin;

        run_pixel_next  = run_pixel_reg;
        run_length_next = run_length_reg;
        run_open_next   = run_open_reg;
        if (accept)
        begin
            if (final_pixel)
            begin
                run_pixel_next  = '0;
                run_length_next = '0;
                run_open_next   = 1'b0;
            end
            else
            begin
                run_pixel_next  = pix1;
                run_length_next = len1;
                run_open_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= CHAN_COUNT_RESET;
            run_pixel_reg  <= '0;
            run_length_reg <= '0;
            run_open_reg   <= 1'b0;
        end
        else
        begin
            if (channel_count_we)
            begin
                chan_count_reg <= channel_count;
            end
            run_pixel_reg  <= run_pixel_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
        end
    end

`ifndef SYNTHESIS
    a_len_nonzero_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        run_open_reg |-> (run_length_reg != 8'd0))
        else $error("open run with zero length");
    a_final_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_pixel) |=> !run_open_reg)
        else $error("run still open after final pixel");
`endif

endmodule

### rtl/core/prle_queue.sv
module prle_queue #(
    parameter int unsigned DEPTH = prle_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prle_pkg::push_t   push,
    output logic              space_ok,
    output logic              rec_valid,
    output prle_pkg::record_t rec,
    input  logic              pop
);
    import prle_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    record_t            mem [DEPTH];
    record_t            rd_data_reg;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign space_ok   = count_reg <= CNT_W'(DEPTH - 2);
    assign rec_valid  = count_reg != '0;
    assign rec        = rd_data_reg;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.second_valid)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end
        else if (push.first_valid)
        begin
            wr_ptr_next = wr_ptr_inc;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
                      - CNT_W'(pop);
    end

    // head word is read out on pop
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_inc] <= push.second;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rec_valid)
        else $error("pop from empty record queue");
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> (push.first_valid && space_ok))
        else $error("second record pushed without first or without room");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (!push.first_valid && !pop && rec_valid) |=> rec_valid)
        else $error("queue lost a word");
`endif

endmodule

### rtl/core/prle_back.sv
module prle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    input  prle_pkg::record_t rec,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        run_count,
    output logic [7:0]        out_chan0,
    output logic [7:0]        out_chan1,
    output logic [7:0]        out_chan2,
    output logic [7:0]        out_chan3,
    output logic              last_record
);
    import prle_pkg::*;

    logic    out_valid_reg;
    logic    load;

    assign load = !out_valid_reg || out_ready;
    assign pop  = rec_valid && load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= rec_valid;
        end
    end

    assign out_valid   = out_valid_reg;
    assign run_count   = rec.count;
    assign out_chan0   = rec.pixel[7:0];
    assign out_chan1   = rec.pixel[15:8];
    assign out_chan2   = rec.pixel[23:16];
    assign out_chan3   = rec.pixel[31:24];
    assign last_record = rec.last;

`ifndef SYNTHESIS
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(rec)))
        else $error("output word changed while stalled");
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_count != 8'd0))
        else $error("record with zero run count");
    a_pop_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && !load) |-> !pop)
        else $error("queue popped while output stalled");
`endif

endmodule

### rtl/core/pixel_run_length_encoder.sv
// Run-length encoder for pixels of one to four channel bytes. One pixel word
// is accepted per clock while in_ready is high; a record (run_count plus
// the run pixel) is queued by the pixel that closes the run and then read
// into the output register. A pixel with final_pixel set that also breaks
// a run yields two records, the second with last_record set; records leave
// the small queue at one per cycle while out_ready is high, so in_ready drops
// only while the queue has fewer than two free entries. channel_count may be
// written only while no pixel is in flight; unused output channels read zero.
module pixel_run_length_encoder #(
    parameter int unsigned QUEUE_DEPTH = prle_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       channel_count_we,
    input  logic [2:0] channel_count,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] chan0,
    input  logic [7:0] chan1,
    input  logic [7:0] chan2,
    input  logic [7:0] chan3,
    input  logic       final_pixel,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] run_count,
    output logic [7:0] out_chan0,
    output logic [7:0] out_chan1,
    output logic [7:0] out_chan2,
    output logic [7:0] out_chan3,
    output logic       last_record
);
    import prle_pkg::*;

    push_t   push;
    logic    space_ok;
    logic    rec_valid;
    record_t rec;
    logic    pop;

    prle_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .channel_count_we (channel_count_we),
        .channel_count    (channel_count),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .chan0            (chan0),
        .chan1            (chan1),
        .chan2            (chan2),
        .chan3            (chan3),
        .final_pixel      (final_pixel),
        .space_ok         (space_ok),
        .push             (push)
    );

    prle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .rec_valid (rec_valid),
        .rec       (rec),
        .pop       (pop)
    );

    prle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (rec_valid),
        .rec         (rec),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .run_count   (run_count),
        .out_chan0   (out_chan0),
        .out_chan1   (out_chan1),
        .out_chan2   (out_chan2),
        .out_chan3   (out_chan3),
        .last_record (last_record)
    );

endmodule

### tb/pixel_run_length_encoder_test.sv
`timescale 1ns / 1ps

module pixel_run_length_encoder_test;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       channel_count_we = 1'b0;
    logic [2:0] channel_count = prle_pkg::CHAN_COUNT_RESET;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] chan0 = 8'h00;
    logic [7:0] chan1 = 8'h00;
    logic [7:0] chan2 = 8'h00;
    logic [7:0] chan3 = 8'h00;
    logic       final_pixel = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] run_count;
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [7:0] out_chan3;
    logic       last_record;

    logic [31:0] seen_pixel;

    // encoder state as predicted
    logic [2:0]  cfg_channels = prle_pkg::CHAN_COUNT_RESET;
    logic [31:0] run_pixel = '0;
    logic [7:0]  run_len = '0;
    logic        run_open = 1'b0;

    prle_pkg::record_t pending_records[$];
    prle_pkg::record_t want;

    int unsigned items_sent = 0;
    int unsigned fail_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    pixel_run_length_encoder DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .channel_count_we (channel_count_we),
        .channel_count    (channel_count),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .chan0            (chan0),
        .chan1            (chan1),
        .chan2            (chan2),
        .chan3            (chan3),
        .final_pixel      (final_pixel),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .run_count        (run_count),
        .out_chan0        (out_chan0),
        .out_chan1        (out_chan1),
        .out_chan2        (out_chan2),
        .out_chan3        (out_chan3),
        .last_record      (last_record)
    );

    assign seen_pixel = {out_chan3, out_chan2, out_chan1, out_chan0};

    always #5 clk = ~clk;

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #2000000;
        $display("** pixel_run_length_encoder: FAILED **");
        $finish;
    end

    function automatic logic [31:0] lane_mask(input logic [2:0] cc);
        int          n;
        logic [31:0] m;
        n = (cc == 3'd0) ? 1 : int'(cc);
        if (n > int'(prle_pkg::CHAN_CAP))
        begin
            n = int'(prle_pkg::CHAN_CAP);
        end
        m = '0;
        for (int k = 0; k < n; k++)
        begin
            m[8*k +: 8] = 8'hFF;
        end
        return m;
    endfunction

    task automatic encode_pixel(input logic [31:0] raw, input logic fin);
        logic [31:0] m;
        logic [31:0] pix;
        m = lane_mask(cfg_channels);
        pix = raw & m;
        if (run_open && pix == (run_pixel & m) && run_len < prle_pkg::RUN_LIMIT)
        begin
            run_len++;
        end
        else
        begin
            if (run_open)
            begin
                pending_records.push_back('{count: run_len, pixel: run_pixel & m, last: 1'b0});
            end
            run_pixel = pix;
            run_len = 8'd1;
            run_open = 1'b1;
        end
        if (fin)
        begin
            pending_records.push_back('{count: run_len, pixel: run_pixel & m, last: 1'b1});
            run_pixel = '0;
            run_len = '0;
            run_open = 1'b0;
        end
    endtask

    // offer one pixel word, entered and left at a falling edge
    task automatic send_pixel(input logic [31:0] pix, input logic fin);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid = 1'b1;
        {chan3, chan2, chan1, chan0} = pix;
        final_pixel = fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        encode_pixel(pix, fin);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_records.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic set_channels(input logic [2:0] value);
        wait_idle();
        channel_count_we = 1'b1;
        channel_count = value;
        @(negedge clk);
        channel_count_we = 1'b0;
        cfg_channels = value;
    endtask

    // receiver side
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left = 100;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready = 1'b1;
            if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_records.size() == 0)
            begin
                $display("%0t: unexpected record, got count %0d pixel %08h last %0b",
                         $time, run_count, seen_pixel, last_record);
                fail_count++;
            end
            else
            begin
                want = pending_records.pop_front();
                if (want.count !== run_count)
                begin
                    $display("%0t: run_count expected %0d, got %0d", $time, want.count, run_count);
                    fail_count++;
                end
                for (int k = 0; k < 4; k++)
                begin
                    if (want.pixel[8*k +: 8] !== seen_pixel[8*k +: 8])
                    begin
                        $display("%0t: out_chan%0d expected %02h, got %02h", $time, k,
                                 want.pixel[8*k +: 8], seen_pixel[8*k +: 8]);
                        fail_count++;
                    end
                end
                if (want.last !== last_record)
                begin
                    $display("%0t: last_record expected %0b, got %0b", $time, want.last,
                             last_record);
                    fail_count++;
                end
            end
        end
    end

    // three channels out of reset, top byte ignored
    task automatic test_reset_count();
        send_pixel(32'h00000000, 1'b0);
        send_pixel(32'h00000000, 1'b0);
        send_pixel(32'hFF000000, 1'b0);
        send_pixel(32'h00FFFFFF, 1'b0);
        send_pixel(32'hFFFFFFFF, 1'b0);
        send_pixel(32'h00FF00FF, 1'b1);
    endtask

    task automatic test_final_cases();
        set_channels(3'd2);
        send_pixel(32'h00001234, 1'b1);
        send_pixel(32'h0000FFFF, 1'b1);
        send_pixel(32'h5500AB00, 1'b0);
        send_pixel(32'h0000AB00, 1'b0);
        send_pixel(32'hAA00AB00, 1'b1);
        send_pixel(32'h00000001, 1'b0);
        send_pixel(32'h00000002, 1'b1);
    endtask

    // every register value, out-of-range ones included
    task automatic test_channel_counts();
        for (int v = 0; v < 8; v++)
        begin
            set_channels(3'(v));
            send_pixel(32'h11223344, 1'b0);
            send_pixel(32'hEEDD3344, 1'b1);
        end
    endtask

    // count changed while a run is open
    task automatic test_count_change();
        set_channels(3'd4);
        send_pixel(32'hDEADBEEF, 1'b0);
        set_channels(3'd1);
        send_pixel(32'h000000EF, 1'b0);
        send_pixel(32'h123456EF, 1'b1);
        send_pixel(32'hFFFFFFEF, 1'b0);
        set_channels(3'd4);
        send_pixel(32'h000000EF, 1'b0);
        send_pixel(32'h000000EF, 1'b1);
    endtask

    // full run, then an equal final pixel still breaks it
    task automatic test_run_limit();
        set_channels(3'd1);
        repeat (255) send_pixel({24'($urandom), 8'h77}, 1'b0);
        send_pixel({24'($urandom), 8'h77}, 1'b1);
    endtask

    // receiver holds off while every pixel breaks the run
    task automatic test_backpressure();
        set_channels(3'd4);
        tx_idle = 1'b0;
        hold_requests++;
        for (int i = 0; i < 40; i++)
        begin
            send_pixel({8'(i), 24'($urandom)}, i == 39);
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_pixel(32'hCAFEF00D, 1'b0);
        send_pixel(32'h0BADBEEF, 1'b0);
        send_pixel(32'h0BADBEEF, 1'b0);
        wait_idle();
        send_pixel(32'h0BADBEEF, 1'b0);
        send_pixel(32'h0BADBEEF, 1'b1);
    endtask

    task automatic test_random(input int unsigned target);
        int unsigned goal;
        int unsigned len;
        logic [31:0] palette [4];
        logic [31:0] pix;
        goal = items_sent + target;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                set_channels(3'($urandom_range(0, 7)));
            end
            if (goal - items_sent < target / 5)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            foreach (palette[i])
            begin
                case ($urandom_range(0, 5))
                    0: palette[i] = 32'h00000000;
                    1: palette[i] = 32'hFFFFFFFF;
                    default: palette[i] = $urandom;
                endcase
            end
            pix = palette[0];
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 5))
                    0, 1: pix = pix;
                    2, 3: pix = palette[$urandom_range(0, 3)];
                    4: pix = pix ^ ($urandom & ~lane_mask(cfg_channels));
                    default: pix = $urandom;
                endcase
                // some images are left without an end marker
                send_pixel(pix, (i == len - 1) && ($urandom_range(0, 7) != 0));
            end
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        test_reset_count();
        test_final_cases();
        test_channel_counts();
        test_count_change();
        test_run_limit();
        test_backpressure();
        test_sender_pause();
        test_random(160);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("** pixel_run_length_encoder: PASSED **");
        end
        else
        begin
            $display("** pixel_run_length_encoder: FAILED **");
        end
        $finish;
    end

endmodule
